@@ design/voxel_grid_fill_engine_defines.svh @@
// assertion macros shared by the voxel grid fill engine
`ifndef VOXEL_GRID_FILL_ENGINE_DEFINES_SVH
`define VOXEL_GRID_FILL_ENGINE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define VGFE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define VGFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/vgfe_pkg.sv @@
// types and constants of the voxel grid fill engine
package vgfe_pkg;

  // default grid capacity per axis
  localparam int MAX_DIM_DEF = 32;

  // field widths
  localparam int ACT_W     = 2;
  localparam int CRD_W     = 11;
  localparam int RSQ_W     = 22;
  localparam int CODE_W    = 8;
  localparam int CNT_W     = 16;
  localparam int REG_W     = 6;
  localparam int CFG_IDX_W = 2;

  // signed coordinate math, one bit wider than a field
  localparam int PW   = CRD_W + 1;
  // step of a square: 2*d+1
  localparam int DW   = PW + 1;
  // square of one axis distance, and sum of three
  localparam int SQ_W  = 21;
  localparam int SUM_W = SQ_W + 2;

  // extent register value after reset
  localparam logic [REG_W-1:0] GRID_RST = REG_W'(32);

  // commands
  typedef enum logic [ACT_W-1:0] {
    ACT_PLACE  = 2'd0,
    ACT_CUBOID = 2'd1,
    ACT_SPHERE = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_SQUARE,
    ST_WALK,
    ST_RDWAIT,
    ST_DONE
  } state_e;

endpackage

@@ design/vgfe_in_if.sv @@
// command channel of the voxel grid fill engine
interface vgfe_in_if;
  import vgfe_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [CRD_W-1:0]  pos_x;
  logic signed [CRD_W-1:0]  pos_y;
  logic signed [CRD_W-1:0]  pos_z;
  logic signed [CRD_W-1:0]  end_x;
  logic signed [CRD_W-1:0]  end_y;
  logic signed [CRD_W-1:0]  end_z;
  logic [RSQ_W-1:0]         radius_sq;
  logic [CODE_W-1:0]        block_code;

  modport source (
    output valid, action, pos_x, pos_y, pos_z, end_x, end_y, end_z, radius_sq, block_code,
    input  ready
  );

  modport sink (
    input  valid, action, pos_x, pos_y, pos_z, end_x, end_y, end_z, radius_sq, block_code,
    output ready
  );
endinterface

@@ design/vgfe_out_if.sv @@
// result channel of the voxel grid fill engine
interface vgfe_out_if;
  import vgfe_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] read_value;
  logic [CNT_W-1:0]  voxels_written;

  modport source (
    output valid, read_value, voxels_written,
    input  ready
  );

  modport sink (
    input  valid, read_value, voxels_written,
    output ready
  );
endinterface

@@ design/voxel_grid_fill_engine.sv @@
// Voxel grid fill engine: a MAX_DIM^3 store of 8-bit block codes with place, cuboid fill,
// sphere fill and read commands, one result item per command. One command is worked at a
// time; the engine visits voxels one per cycle through the single write port of the store,
// and a shared step adder keeps the squared distance up to date as the walk advances.
// A cuboid fill walks the clipped box; a sphere fill first squares the centre offsets and
// then walks the whole width*height*depth extent; an empty cuboid or sphere walks nothing.
// After reset the store is swept to zero, one entry per cycle, over all of its
// 2^(3*ceil(log2(MAX_DIM))) entries (32768 at MAX_DIM 32); no command is taken then, but
// extent registers may be written. A finished result waits in an output register, so the
// next command is taken while it is still pending; a later result that finds that register
// occupied waits until it is taken.
`include "voxel_grid_fill_engine_defines.svh"

module voxel_grid_fill_engine #(
  parameter int MAX_DIM = vgfe_pkg::MAX_DIM_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  vgfe_in_if.sink                          req_i,
  vgfe_out_if.source                       rsp_o,
  input  logic                             cfg_we_i,
  input  logic [vgfe_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [vgfe_pkg::REG_W-1:0]       cfg_data_i
);
  import vgfe_pkg::*;

  // coordinate, extent and address widths
  localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int EW    = $clog2(MAX_DIM + 1);
  localparam int AW    = 3 * CW;
  localparam int DEPTH = 1 << AW;
  localparam logic [EW-1:0] MAX_EXT = EW'(MAX_DIM);

  typedef struct packed {
    logic          ok;
    logic [CW-1:0] lo;
    logic [CW-1:0] hi;
  } bnd_t;

  // sign extend a field into coordinate math width
  function automatic logic signed [PW-1:0] sext(input logic signed [CRD_W-1:0] v);
    return {v[CRD_W-1], v};
  endfunction

  // extent as a signed coordinate
  function automatic logic signed [PW-1:0] zext(input logic [EW-1:0] e);
    return {{(PW-EW){1'b0}}, e};
  endfunction

  // extent register clamped to the capacity
  function automatic logic [EW-1:0] clamp_ext(input logic [REG_W-1:0] r);
    logic [EW-1:0] e;
    if (int'(r) > MAX_DIM) begin
      e = MAX_EXT;
    end else begin
      e = EW'(r);
    end
    return e;
  endfunction

  // point lies inside the extent on one axis
  function automatic logic in_axis(input logic signed [CRD_W-1:0] p, input logic [EW-1:0] e);
    return (p >= 0) && (sext(p) < zext(e));
  endfunction

  // ordered and clipped cuboid range on one axis
  function automatic bnd_t box_axis(input logic signed [CRD_W-1:0] p,
                                    input logic signed [CRD_W-1:0] q,
                                    input logic [EW-1:0]           e);
    logic signed [PW-1:0] a;
    logic signed [PW-1:0] b;
    logic signed [PW-1:0] lo;
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] top;
    bnd_t                 r;
    a   = (p < q) ? sext(p) : sext(q);
    b   = (p < q) ? sext(q) : sext(p);
    top = zext(e) - PW'(1);
    lo  = (a < 0) ? '0 : a;
    hi  = (b > top) ? top : b;
    r.ok = (lo <= hi);
    r.lo = lo[CW-1:0];
    r.hi = hi[CW-1:0];
    return r;
  endfunction

  // state
  state_e state_q, state_d;

  // extent registers
  logic [REG_W-1:0] grid_w_q, grid_h_q, grid_d_q;

  // latched command
  logic [ACT_W-1:0]        act_q;
  logic signed [CRD_W-1:0] px_q, py_q, pz_q, ex_q, ey_q, ez_q;
  logic [RSQ_W-1:0]        rsq_q;
  logic [CODE_W-1:0]       code_q;

  // walk bounds and position
  logic [CW-1:0] lo_x_q, lo_y_q, lo_z_q, lo_x_d, lo_y_d, lo_z_d;
  logic [CW-1:0] hi_x_q, hi_y_q, hi_z_q, hi_x_d, hi_y_d, hi_z_d;
  logic [CW-1:0] x_q, y_q, z_q, x_d, y_d, z_d;

  // squared distances of the current position and row starts
  logic [SQ_W-1:0] sx_q, sy_q, sz_q, sy0_q, sz0_q;
  logic [SQ_W-1:0] sx_d, sy_d, sz_d, sy0_d, sz0_d;
  logic [1:0]      sq_cnt_q, sq_cnt_d;

  // clear sweep, count, read value
  logic [AW-1:0]     clr_q, clr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CODE_W-1:0] rv_q, rv_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [CODE_W-1:0] out_rv_q, out_rv_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;

  // store ports
  logic [CODE_W-1:0] mem_q [DEPTH];
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [CODE_W-1:0] mem_wd;
  logic [AW-1:0]     mem_ra;
  logic [CODE_W-1:0] rd_q;

  // clamped extents
  logic [EW-1:0] ext_x, ext_y, ext_z;
  assign ext_x = clamp_ext(grid_w_q);
  assign ext_y = clamp_ext(grid_h_q);
  assign ext_z = clamp_ext(grid_d_q);

  // point check and point address
  logic          pt_in;
  logic [AW-1:0] pt_addr;
  assign pt_in   = in_axis(px_q, ext_x) && in_axis(py_q, ext_y) && in_axis(pz_q, ext_z);
  assign pt_addr = {px_q[CW-1:0], py_q[CW-1:0], pz_q[CW-1:0]};
  assign mem_ra  = pt_addr;

  // cuboid bounds
  bnd_t bx, by, bz;
  assign bx = box_axis(px_q, ex_q, ext_x);
  assign by = box_axis(py_q, ey_q, ext_y);
  assign bz = box_axis(pz_q, ez_q, ext_z);

  // sphere bounds span the whole grid
  logic [EW-1:0] top_x, top_y, top_z;
  logic          sph_ok;
  assign top_x  = ext_x - EW'(1);
  assign top_y  = ext_y - EW'(1);
  assign top_z  = ext_z - EW'(1);
  assign sph_ok = (ext_x != '0) && (ext_y != '0) && (ext_z != '0);

  // shared squarer for the centre distances at coordinate zero
  logic signed [CRD_W-1:0]   mul_in;
  logic signed [2*CRD_W-1:0] mul_prod;
  logic [SQ_W-1:0]           mul_sq;
  always_comb begin
    case (sq_cnt_q)
      2'd0:    mul_in = px_q;
      2'd1:    mul_in = py_q;
      default: mul_in = pz_q;
    endcase
  end
  assign mul_prod = mul_in * mul_in;
  assign mul_sq   = mul_prod[SQ_W-1:0];

  // walk wrap flags
  logic x_last, y_last, z_last;
  assign x_last = (x_q == hi_x_q);
  assign y_last = (y_q == hi_y_q);
  assign z_last = (z_q == hi_z_q);

  // shared step unit: (c+1-p)^2 = (c-p)^2 + 2(c-p) + 1 on the advancing axis
  logic [CW-1:0]           st_c;
  logic signed [CRD_W-1:0] st_p;
  logic [SQ_W-1:0]         st_sq;
  logic signed [PW-1:0]    st_diff;
  logic [DW-1:0]           st_delta;
  logic [SQ_W+1:0]         st_sum;
  logic [SQ_W-1:0]         st_new;
  always_comb begin
    if (!z_last) begin
      st_c  = z_q;
      st_p  = pz_q;
      st_sq = sz_q;
    end else if (!y_last) begin
      st_c  = y_q;
      st_p  = py_q;
      st_sq = sy_q;
    end else begin
      st_c  = x_q;
      st_p  = px_q;
      st_sq = sx_q;
    end
  end
  assign st_diff  = $signed({{(PW-CW){1'b0}}, st_c}) - sext(st_p);
  assign st_delta = {st_diff, 1'b1};
  assign st_sum   = {2'b00, st_sq} + {{(SQ_W+2-DW){st_delta[DW-1]}}, st_delta};
  assign st_new   = st_sum[SQ_W-1:0];

  // sphere membership of the current voxel
  logic [SUM_W-1:0] dist_sum;
  logic             hit;
  assign dist_sum = {2'b00, sx_q} + {2'b00, sy_q} + {2'b00, sz_q};
  assign hit      = (dist_sum <= {{(SUM_W-RSQ_W){1'b0}}, rsq_q});

  // saturating count step
  logic [CNT_W-1:0] cnt_inc;
  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + CNT_W'(1);

  // handshakes
  logic in_acc, out_acc;
  assign req_i.ready          = (state_q == ST_IDLE);
  assign in_acc               = req_i.valid && req_i.ready;
  assign out_acc              = out_valid_q && rsp_o.ready;
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.read_value     = out_rv_q;
  assign rsp_o.voxels_written = out_cnt_q;

  // sequencer next state and datapath controls
  always_comb begin
    state_d     = state_q;
    lo_x_d      = lo_x_q;
    lo_y_d      = lo_y_q;
    lo_z_d      = lo_z_q;
    hi_x_d      = hi_x_q;
    hi_y_d      = hi_y_q;
    hi_z_d      = hi_z_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    sz_d        = sz_q;
    sy0_d       = sy0_q;
    sz0_d       = sz0_q;
    sq_cnt_d    = sq_cnt_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    rv_d        = rv_q;
    out_valid_d = out_valid_q && !out_acc;
    out_rv_d    = out_rv_q;
    out_cnt_d   = out_cnt_q;
    mem_we      = 1'b0;
    mem_wa      = {x_q, y_q, z_q};
    mem_wd      = code_q;

    case (state_q)
      // sweep the store to zero after reset
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
        clr_d  = clr_q + AW'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          cnt_d   = '0;
          rv_d    = '0;
          state_d = ST_SETUP;
        end
      end

      // decode the command, resolve bounds, handle single-voxel commands
      ST_SETUP: begin
        state_d = ST_DONE;
        case (act_q)
          ACT_PLACE: begin
            if (pt_in) begin
              mem_we = 1'b1;
              mem_wa = pt_addr;
              cnt_d  = CNT_W'(1);
            end
          end
          ACT_CUBOID: begin
            lo_x_d = bx.lo;
            lo_y_d = by.lo;
            lo_z_d = bz.lo;
            hi_x_d = bx.hi;
            hi_y_d = by.hi;
            hi_z_d = bz.hi;
            x_d    = bx.lo;
            y_d    = by.lo;
            z_d    = bz.lo;
            if (bx.ok && by.ok && bz.ok) begin
              state_d = ST_WALK;
            end
          end
          ACT_SPHERE: begin
            lo_x_d   = '0;
            lo_y_d   = '0;
            lo_z_d   = '0;
            hi_x_d   = top_x[CW-1:0];
            hi_y_d   = top_y[CW-1:0];
            hi_z_d   = top_z[CW-1:0];
            x_d      = '0;
            y_d      = '0;
            z_d      = '0;
            sq_cnt_d = '0;
            if (sph_ok) begin
              state_d = ST_SQUARE;
            end
          end
          ACT_READ: begin
            if (pt_in) begin
              state_d = ST_RDWAIT;
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end

      // squares of the centre offsets at the grid origin, one axis a cycle
      ST_SQUARE: begin
        sq_cnt_d = sq_cnt_q + 2'd1;
        case (sq_cnt_q)
          2'd0: begin
            sx_d = mul_sq;
          end
          2'd1: begin
            sy_d  = mul_sq;
            sy0_d = mul_sq;
          end
          default: begin
            sz_d    = mul_sq;
            sz0_d   = mul_sq;
            state_d = ST_WALK;
          end
        endcase
      end

      // one voxel a cycle, z fastest
      ST_WALK: begin
        if ((act_q == ACT_CUBOID) || hit) begin
          mem_we = 1'b1;
          cnt_d  = cnt_inc;
        end
        if (!z_last) begin
          z_d  = z_q + CW'(1);
          sz_d = st_new;
        end else begin
          z_d  = lo_z_q;
          sz_d = sz0_q;
          if (!y_last) begin
            y_d  = y_q + CW'(1);
            sy_d = st_new;
          end else begin
            y_d  = lo_y_q;
            sy_d = sy0_q;
            if (!x_last) begin
              x_d  = x_q + CW'(1);
              sx_d = st_new;
            end else begin
              state_d = ST_DONE;
            end
          end
        end
      end

      // registered read data is ready
      ST_RDWAIT: begin
        rv_d    = rd_q;
        state_d = ST_DONE;
      end

      // hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_rv_d    = rv_q;
          out_cnt_d   = cnt_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      grid_w_q    <= GRID_RST;
      grid_h_q    <= GRID_RST;
      grid_d_q    <= GRID_RST;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH:  grid_w_q <= cfg_data_i;
          CFG_HEIGHT: grid_h_q <= cfg_data_i;
          CFG_DEPTH:  grid_d_q <= cfg_data_i;
          default:    ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= req_i.action;
      px_q   <= req_i.pos_x;
      py_q   <= req_i.pos_y;
      pz_q   <= req_i.pos_z;
      ex_q   <= req_i.end_x;
      ey_q   <= req_i.end_y;
      ez_q   <= req_i.end_z;
      rsq_q  <= req_i.radius_sq;
      code_q <= req_i.block_code;
    end
    lo_x_q    <= lo_x_d;
    lo_y_q    <= lo_y_d;
    lo_z_q    <= lo_z_d;
    hi_x_q    <= hi_x_d;
    hi_y_q    <= hi_y_d;
    hi_z_q    <= hi_z_d;
    x_q       <= x_d;
    y_q       <= y_d;
    z_q       <= z_d;
    sx_q      <= sx_d;
    sy_q      <= sy_d;
    sz_q      <= sz_d;
    sy0_q     <= sy0_d;
    sz0_q     <= sz0_d;
    sq_cnt_q  <= sq_cnt_d;
    cnt_q     <= cnt_d;
    rv_q      <= rv_d;
    out_rv_q  <= out_rv_d;
    out_cnt_q <= out_cnt_d;
  end

  // voxel store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[mem_ra];
  end

  // the store is only written while a command or the clear sweep runs
  `VGFE_ASSERT_NOW(a_no_write_idle, clk_i, rst_ni,
    (state_q == ST_IDLE) || (state_q == ST_DONE), !mem_we, "store written while idle")

  // the walk never leaves its box
  `VGFE_ASSERT_NOW(a_walk_in_box, clk_i, rst_ni, state_q == ST_WALK,
    (x_q <= hi_x_q) && (y_q <= hi_y_q) && (z_q <= hi_z_q), "walk outside its bounds")

  // sphere row start restores the saved square
  `VGFE_ASSERT_NOW(a_row_square, clk_i, rst_ni,
    (state_q == ST_WALK) && (act_q == ACT_SPHERE) && (z_q == '0), sz_q == sz0_q,
    "sphere row started with a stale square")

  // finishing a command always presents a result
  `VGFE_ASSERT_NEXT(a_done_result, clk_i, rst_ni,
    (state_q == ST_DONE) && (state_d == ST_IDLE), out_valid_q, "finished command lost")

endmodule

@@ sim/tb.sv @@
// self-checking testbench for the voxel grid fill engine: directed and random commands
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vgfe_pkg::*;

  localparam int DIM = MAX_DIM_DEF;

  // one command item and one result item
  typedef struct {
    action_e                 action;
    logic signed [CRD_W-1:0] pos_x, pos_y, pos_z;
    logic signed [CRD_W-1:0] end_x, end_y, end_z;
    logic [RSQ_W-1:0]        radius_sq;
    logic [CODE_W-1:0]       block_code;
  } command_t;

  typedef struct {
    logic [CODE_W-1:0] read_value;
    logic [CNT_W-1:0]  voxels_written;
  } reply_t;

  // shadow copy of the voxel grid, predicts the reply of every accepted command
  class grid_shadow;
    logic [CODE_W-1:0] vox [DIM*DIM*DIM];
    int                ext_x, ext_y, ext_z;
    reply_t            expected_replies [$];
    int                errors;

    function new();
      foreach (vox[i]) vox[i] = '0;
      ext_x  = DIM;
      ext_y  = DIM;
      ext_z  = DIM;
      errors = 0;
    endfunction

    // extent registers clamp at the store size
    function void set_extent(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      int len;
      len = (val > DIM) ? DIM : int'(val);
      case (idx)
        CFG_WIDTH:  ext_x = len;
        CFG_HEIGHT: ext_y = len;
        CFG_DEPTH:  ext_z = len;
        default: ;
      endcase
    endfunction

    function bit in_grid(int x, int y, int z);
      return x >= 0 && y >= 0 && z >= 0 && x < ext_x && y < ext_y && z < ext_z;
    endfunction

    // apply one accepted command to the grid and queue its reply
    function void note_command(command_t c);
      int          px, py, pz, qx, qy, qz;
      int          x0, x1, y0, y1, z0, z1;
      longint      dx, dy, dz;
      int unsigned count;
      reply_t      r;
      px = c.pos_x; py = c.pos_y; pz = c.pos_z;
      qx = c.end_x; qy = c.end_y; qz = c.end_z;
      count = 0;
      r.read_value = '0;
      case (c.action)
        ACT_PLACE: begin
          if (in_grid(px, py, pz)) begin
            vox[(px * DIM + py) * DIM + pz] = c.block_code;
            count = 1;
          end
        end
        ACT_CUBOID: begin
          // order each axis, then clip to the grid
          x0 = (px < qx) ? px : qx;  x1 = (px < qx) ? qx : px;
          y0 = (py < qy) ? py : qy;  y1 = (py < qy) ? qy : py;
          z0 = (pz < qz) ? pz : qz;  z1 = (pz < qz) ? qz : pz;
          if (x0 < 0) x0 = 0;
          if (y0 < 0) y0 = 0;
          if (z0 < 0) z0 = 0;
          if (x1 > ext_x - 1) x1 = ext_x - 1;
          if (y1 > ext_y - 1) y1 = ext_y - 1;
          if (z1 > ext_z - 1) z1 = ext_z - 1;
          for (int x = x0; x <= x1; x++)
            for (int y = y0; y <= y1; y++)
              for (int z = z0; z <= z1; z++) begin
                vox[(x * DIM + y) * DIM + z] = c.block_code;
                count++;
              end
        end
        ACT_SPHERE: begin
          for (int x = 0; x < ext_x; x++)
            for (int y = 0; y < ext_y; y++)
              for (int z = 0; z < ext_z; z++) begin
                dx = x - px;
                dy = y - py;
                dz = z - pz;
                if (dx * dx + dy * dy + dz * dz <= longint'(c.radius_sq)) begin
                  vox[(x * DIM + y) * DIM + z] = c.block_code;
                  count++;
                end
              end
        end
        default: begin
          if (in_grid(px, py, pz)) r.read_value = vox[(px * DIM + py) * DIM + pz];
        end
      endcase
      if (count > 65535) count = 65535;
      r.voxels_written = CNT_W'(count);
      expected_replies.push_back(r);
    endfunction

    // compare one accepted result item with the oldest expectation
    function void check_result(logic [CODE_W-1:0] rv, logic [CNT_W-1:0] cnt);
      reply_t r;
      if (expected_replies.size() == 0) begin
        $error("unexpected result item: read_value %0d voxels_written %0d", rv, cnt);
        errors++;
        return;
      end
      r = expected_replies.pop_front();
      if (rv !== r.read_value) begin
        $error("read_value mismatch: expected %0d actual %0d", r.read_value, rv);
        errors++;
      end
      if (cnt !== r.voxels_written) begin
        $error("voxels_written mismatch: expected %0d actual %0d", r.voxels_written, cnt);
        errors++;
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [REG_W-1:0]     cfg_data_i;

  vgfe_in_if  req_if ();
  vgfe_out_if rsp_if ();

  voxel_grid_fill_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  grid_shadow shadow = new();
  int         snd_idle_pct = 11;
  int         rcv_idle_pct = 83;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      shadow.check_result(rsp_if.read_value, rsp_if.voxels_written);
  end

  function automatic command_t mk(action_e a, int px, int py, int pz, int qx, int qy, int qz,
                                  int unsigned rsq, int code);
    command_t c;
    c.action     = a;
    c.pos_x      = CRD_W'(px);
    c.pos_y      = CRD_W'(py);
    c.pos_z      = CRD_W'(pz);
    c.end_x      = CRD_W'(qx);
    c.end_y      = CRD_W'(qy);
    c.end_z      = CRD_W'(qz);
    c.radius_sq  = RSQ_W'(rsq);
    c.block_code = CODE_W'(code);
    return c;
  endfunction

  // mostly around the grid, sometimes anywhere in the field range
  function automatic int near_coord(int len);
    int roll;
    roll = $urandom_range(99);
    if (roll < 78) return int'($urandom_range(len + 3)) - 2;
    else if (roll < 90) return int'($urandom_range(2047)) - 1024;
    else if (roll < 95) return -1024;
    else return 1023;
  endfunction

  function automatic command_t rand_command();
    command_t c;
    int       roll;
    int       reach;
    roll = $urandom_range(99);
    if (roll < 30) c.action = ACT_PLACE;
    else if (roll < 55) c.action = ACT_CUBOID;
    else if (roll < 75) c.action = ACT_SPHERE;
    else c.action = ACT_READ;
    c.pos_x      = CRD_W'(near_coord(shadow.ext_x));
    c.pos_y      = CRD_W'(near_coord(shadow.ext_y));
    c.pos_z      = CRD_W'(near_coord(shadow.ext_z));
    c.end_x      = CRD_W'(near_coord(shadow.ext_x));
    c.end_y      = CRD_W'(near_coord(shadow.ext_y));
    c.end_z      = CRD_W'(near_coord(shadow.ext_z));
    c.block_code = CODE_W'($urandom_range(255));
    reach = shadow.ext_x * shadow.ext_x + shadow.ext_y * shadow.ext_y
          + shadow.ext_z * shadow.ext_z;
    roll = $urandom_range(99);
    if (c.action == ACT_SPHERE && roll < 60) c.radius_sq = RSQ_W'($urandom_range(reach));
    else if (c.action == ACT_SPHERE && roll < 80) c.radius_sq = RSQ_W'($urandom_range(4));
    else c.radius_sq = RSQ_W'($urandom_range((1 << RSQ_W) - 1));
    return c;
  endfunction

  // send one command item, with random idle cycles in front
  task automatic push_command(command_t c);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.action     <= c.action;
    req_if.pos_x      <= c.pos_x;
    req_if.pos_y      <= c.pos_y;
    req_if.pos_z      <= c.pos_z;
    req_if.end_x      <= c.end_x;
    req_if.end_y      <= c.end_y;
    req_if.end_z      <= c.end_z;
    req_if.radius_sq  <= c.radius_sq;
    req_if.block_code <= c.block_code;
    do @(posedge clk_i); while (!req_if.ready);
    shadow.note_command(c);
  endtask

  // stop sending and wait until every reply has come back
  task automatic drain();
    req_if.valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_grid(int w, int h, int d);
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_WIDTH; cfg_data_i <= REG_W'(w);
    @(posedge clk_i);
    cfg_idx_i <= CFG_HEIGHT; cfg_data_i <= REG_W'(h);
    @(posedge clk_i);
    cfg_idx_i <= CFG_DEPTH; cfg_data_i <= REG_W'(d);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow.set_extent(CFG_WIDTH, REG_W'(w));
    shadow.set_extent(CFG_HEIGHT, REG_W'(h));
    shadow.set_extent(CFG_DEPTH, REG_W'(d));
  endtask

  // grid settings of the random phases: zero, one, full and clamped extents
  int grid_w [11] = '{1, 0, 4, 63, 8, 5, 3, 7, 2, 6, 32};
  int grid_h [11] = '{1, 5, 4, 2,  8, 0, 32, 6, 3, 7, 32};
  int grid_d [11] = '{1, 5, 4, 3,  8, 63, 2, 0, 32, 5, 1};

  initial begin
    req_if.valid      = 1'b0;
    req_if.action     = ACT_PLACE;
    req_if.pos_x      = '0;
    req_if.pos_y      = '0;
    req_if.pos_z      = '0;
    req_if.end_x      = '0;
    req_if.end_y      = '0;
    req_if.end_z      = '0;
    req_if.radius_sq  = '0;
    req_if.block_code = '0;
    rsp_if.ready      = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_WIDTH;
    cfg_data_i        = '0;
    rst_ni            = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part on the full reset grid
    push_command(mk(ACT_READ,   0, 0, 0, 0, 0, 0, 0, 0));
    push_command(mk(ACT_PLACE,  0, 0, 0, 0, 0, 0, 0, 8'hFF));
    push_command(mk(ACT_PLACE,  31, 31, 31, 0, 0, 0, 0, 8'h01));
    push_command(mk(ACT_PLACE,  32, 0, 0, 0, 0, 0, 0, 8'h77));
    push_command(mk(ACT_PLACE,  -1, 5, 5, 0, 0, 0, 0, 8'h12));
    push_command(mk(ACT_PLACE,  -1024, -1024, -1024, 0, 0, 0, 0, 8'h34));
    push_command(mk(ACT_PLACE,  1023, 1023, 1023, 0, 0, 0, 0, 8'h56));
    push_command(mk(ACT_READ,   0, 0, 0, 0, 0, 0, 0, 0));
    push_command(mk(ACT_READ,   31, 31, 31, 0, 0, 0, 0, 0));
    push_command(mk(ACT_READ,   32, 0, 0, 0, 0, 0, 0, 0));
    push_command(mk(ACT_READ,   -1024, -1024, -1024, 0, 0, 0, 0, 0));
    // corners given high to low, partly outside, fully outside
    push_command(mk(ACT_CUBOID, 5, 4, 3, 2, 1, 0, 0, 8'h55));
    push_command(mk(ACT_CUBOID, -3, -3, -3, 1, 1, 1, 0, 8'h66));
    push_command(mk(ACT_CUBOID, 40, 40, 40, 50, 50, 50, 0, 8'h77));
    push_command(mk(ACT_READ,   3, 2, 1, 0, 0, 0, 0, 0));
    // zero radius, and centre outside the grid
    push_command(mk(ACT_SPHERE, 3, 3, 3, 0, 0, 0, 0, 8'h9A));
    push_command(mk(ACT_SPHERE, -5, 0, 0, 0, 0, 0, 9, 8'hBC));
    push_command(mk(ACT_READ,   0, 0, 0, 0, 0, 0, 0, 0));
    // whole grid by the widest box and the largest radius
    push_command(mk(ACT_CUBOID, -1024, -1024, -1024, 1023, 1023, 1023, 0, 8'hAA));
    push_command(mk(ACT_SPHERE, -1024, -1024, -1024, 0, 0, 0, (1 << RSQ_W) - 1, 8'hC3));
    push_command(mk(ACT_READ,   1023, 1023, 1023, 0, 0, 0, 0, 0));
    push_command(mk(ACT_READ,   17, 9, 30, 0, 0, 0, 0, 0));

    // random phases, each on its own grid size
    for (int p = 0; p < 11; p++) begin
      if (p == 4) begin
        snd_idle_pct = 83;
        rcv_idle_pct = 11;
      end else if (p == 8) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      drain();
      set_grid(grid_w[p], grid_h[p], grid_d[p]);
      repeat (7) push_command(rand_command());
    end

    drain();
    repeat (64) @(posedge clk_i);
    if (shadow.pending() != 0) begin
      $error("%0d expected result items never arrived", shadow.pending());
      shadow.errors++;
    end
    if (shadow.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
